// ===== rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// sst_pkg
// Shared types and codes of the sorted symbol table: action and status codes,
// sequencer states, and the control and sweep packet structs of the cell chain.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int RANK_W = 6;

  localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT_NEW = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd2;
  localparam logic [ACT_W-1:0] ACT_SELECT     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_RANK = 2'd3;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SWEEP,
    SEQ_APPLY
  } seq_state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             ins_go;
  } sst_ctl_t;

  // sweep packet flags handed from cell to cell
  typedef struct packed {
    logic tok;
    logic found;
  } sst_pkt_t;

endpackage

// ===== rtl/sst_cell.sv =====
// ----------------------------------------------------------------------------
// sst_cell
// One slot of the sorted table. Holds a key and a value, compares them with
// the current command, passes the sweep packet to its right-hand neighbour,
// shifts right on insert and left behind a deleted entry.
// ----------------------------------------------------------------------------
module sst_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 16,
  parameter int CW         = 7,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  sst_pkg::sst_ctl_t     ctl,
  input  logic [KEY_BITS-1:0]   cmd_key,
  input  logic [VALUE_BITS-1:0] cmd_value,
  input  logic [CW-1:0]         cmd_rank,
  input  logic [CW-1:0]         count,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [VALUE_BITS-1:0] left_value,
  input  logic                  left_lt,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [VALUE_BITS-1:0] right_value,
  input  sst_pkg::sst_pkt_t     pkt_in,
  input  logic [KEY_BITS-1:0]   pkt_key_in,
  input  logic [VALUE_BITS-1:0] pkt_value_in,
  output logic [KEY_BITS-1:0]   key_o,
  output logic [VALUE_BITS-1:0] value_o,
  output logic                  lt_o,
  output sst_pkg::sst_pkt_t     pkt_o,
  output logic [KEY_BITS-1:0]   pkt_key_o,
  output logic [VALUE_BITS-1:0] pkt_value_o
);

  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  sst_pkg::sst_pkt_t     pkt_r, pkt_nxt;
  logic [KEY_BITS-1:0]   pkt_key_r, pkt_key_nxt;
  logic [VALUE_BITS-1:0] pkt_value_r, pkt_value_nxt;
  logic                  occ;
  logic                  key_eq;
  logic                  hit;

  always_comb begin
    occ    = CW'(IDX) < count;
    key_eq = occ && (key_r == cmd_key);
    lt_o   = occ && ($signed(key_r) < $signed(cmd_key));
    case (ctl.action)
      sst_pkg::ACT_INSERT,
      sst_pkg::ACT_INSERT_NEW,
      sst_pkg::ACT_SEARCH: begin
        hit = key_eq && !pkt_in.found;
      end
      sst_pkg::ACT_SELECT: begin
        hit = occ && (cmd_rank == CW'(IDX));
      end
      sst_pkg::ACT_DELETE: begin
        hit = key_eq && (value_r == cmd_value) && !pkt_in.found;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    hit           = hit && pkt_in.tok;
    pkt_nxt.tok   = pkt_in.tok;
    pkt_nxt.found = pkt_in.tok && (pkt_in.found || hit);
    pkt_key_nxt   = hit ? key_r : pkt_key_in;
    pkt_value_nxt = hit ? value_r : pkt_value_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r <= '0;
    end else begin
      pkt_r <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pkt_key_r   <= pkt_key_nxt;
    pkt_value_r <= pkt_value_nxt;
    if (ctl.ins_go) begin
      if (!lt_o) begin
        key_r   <= left_lt ? cmd_key : left_key;
        value_r <= left_lt ? cmd_value : left_value;
      end
    end else if (ctl.action == sst_pkg::ACT_DELETE && pkt_r.tok && pkt_r.found) begin
      // entry at or after the deleted one closes the gap
      key_r   <= right_key;
      value_r <= right_value;
    end
  end

  assign key_o       = key_r;
  assign value_o     = value_r;
  assign pkt_o       = pkt_r;
  assign pkt_key_o   = pkt_key_r;
  assign pkt_value_o = pkt_value_r;

endmodule

// ===== rtl/sorted_symbol_table_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_symbol_table_unit
// Ordered symbol table kept sorted in a chain of cells, with a sequencer that
// sweeps a packet down the chain for lookups and deletes and applies inserts.
// ----------------------------------------------------------------------------
//  channel | dir | tuser         | tdata
//  in_     | in  | action        | key, value, rank
//  out_    | out | status        | out_key, out_value, entry_count, is_empty
//
//  one word at a time: a packet walks the chain one cell a cycle, then the apply
//  state shifts the cells for an insert and loads the output register
//  rst_n clears the fill count and control; cell contents are left as they are
//  in_tready is high only while the sequencer is idle; a stalled result waits in
//  the output register and holds the apply cycle until it is taken
// ----------------------------------------------------------------------------
module sorted_symbol_table_unit #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 16,
  localparam int CNT_W     = $clog2(CAPACITY + 1),
  localparam int IN_RAW    = KEY_BITS + VALUE_BITS + sst_pkg::RANK_W,
  localparam int IN_W      = (IN_RAW + 7) / 8 * 8,
  localparam int OUT_RAW   = KEY_BITS + VALUE_BITS + CNT_W + 1,
  localparam int OUT_W     = (OUT_RAW + 7) / 8 * 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_W-1:0]           in_tdata,   // key, value, rank
  input  logic [sst_pkg::ACT_W-1:0] in_tuser,   // action
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_W-1:0]          out_tdata,  // out_key, out_value, entry_count, is_empty
  output logic [sst_pkg::STAT_W-1:0] out_tuser  // status
);

  localparam int CW = (CNT_W > sst_pkg::RANK_W) ? CNT_W : sst_pkg::RANK_W;

  sst_pkg::seq_state_t         state_r, state_nxt;
  logic [sst_pkg::ACT_W-1:0]   act_r;
  logic [KEY_BITS-1:0]         key_r;
  logic [VALUE_BITS-1:0]       value_r;
  logic [sst_pkg::RANK_W-1:0]  rank_r;
  logic [CNT_W-1:0]            count_r, count_nxt;
  logic                        launch_r;
  logic                        res_found_r;
  logic [KEY_BITS-1:0]         res_key_r;
  logic [VALUE_BITS-1:0]       res_value_r;
  logic                        out_valid_r;
  logic [sst_pkg::STAT_W-1:0]  out_status_r, status_nxt;
  logic [OUT_W-1:0]            out_data_r;
  logic [KEY_BITS-1:0]         okey_nxt;
  logic [VALUE_BITS-1:0]       oval_nxt;
  logic                        in_acc;
  logic                        finish;
  logic                        ins_go;
  logic                        full;
  sst_pkg::sst_ctl_t           ctl;
  sst_pkg::sst_pkt_t           launch_pkt;

  logic [KEY_BITS-1:0]         cell_key   [CAPACITY];
  logic [VALUE_BITS-1:0]       cell_value [CAPACITY];
  logic                        cell_lt    [CAPACITY];
  sst_pkg::sst_pkt_t           cell_pkt   [CAPACITY];
  logic [KEY_BITS-1:0]         cell_pkey  [CAPACITY];
  logic [VALUE_BITS-1:0]       cell_pval  [CAPACITY];

  assign in_tready = (state_r == sst_pkg::SEQ_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign full      = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    state_nxt  = state_r;
    finish     = 1'b0;
    ins_go     = 1'b0;
    count_nxt  = count_r;
    status_nxt = sst_pkg::STAT_OK;
    okey_nxt   = '0;
    oval_nxt   = '0;
    case (act_r)
      sst_pkg::ACT_INSERT: begin
        status_nxt = full ? sst_pkg::STAT_FULL : sst_pkg::STAT_OK;
      end
      sst_pkg::ACT_INSERT_NEW: begin
        status_nxt = res_found_r ? sst_pkg::STAT_MISS :
                     full        ? sst_pkg::STAT_FULL : sst_pkg::STAT_OK;
      end
      sst_pkg::ACT_SEARCH: begin
        status_nxt = res_found_r ? sst_pkg::STAT_OK : sst_pkg::STAT_MISS;
        okey_nxt   = res_found_r ? res_key_r : '0;
        oval_nxt   = res_found_r ? res_value_r : '0;
      end
      sst_pkg::ACT_SELECT: begin
        status_nxt = res_found_r ? sst_pkg::STAT_OK : sst_pkg::STAT_RANK;
        okey_nxt   = res_found_r ? res_key_r : '0;
        oval_nxt   = res_found_r ? res_value_r : '0;
      end
      sst_pkg::ACT_DELETE: begin
        status_nxt = res_found_r ? sst_pkg::STAT_OK : sst_pkg::STAT_MISS;
      end
      default: begin
        status_nxt = sst_pkg::STAT_OK;
      end
    endcase
    case (state_r)
      sst_pkg::SEQ_IDLE: begin
        if (in_acc) begin
          state_nxt = sst_pkg::SEQ_SWEEP;
        end
      end
      sst_pkg::SEQ_SWEEP: begin
        if (cell_pkt[CAPACITY-1].tok) begin
          state_nxt = sst_pkg::SEQ_APPLY;
        end
      end
      sst_pkg::SEQ_APPLY: begin
        if (!out_valid_r || out_tready) begin
          finish    = 1'b1;
          state_nxt = sst_pkg::SEQ_IDLE;
          if (status_nxt == sst_pkg::STAT_OK &&
              (act_r inside {sst_pkg::ACT_INSERT, sst_pkg::ACT_INSERT_NEW})) begin
            ins_go    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else if (status_nxt == sst_pkg::STAT_OK && act_r == sst_pkg::ACT_DELETE) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        state_nxt = sst_pkg::SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sst_pkg::SEQ_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      launch_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      launch_r <= in_acc;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r   <= in_tuser;
      key_r   <= in_tdata[KEY_BITS-1:0];
      value_r <= in_tdata[KEY_BITS +: VALUE_BITS];
      rank_r  <= in_tdata[KEY_BITS+VALUE_BITS +: sst_pkg::RANK_W];
    end
    if (state_r == sst_pkg::SEQ_SWEEP && cell_pkt[CAPACITY-1].tok) begin
      res_found_r <= cell_pkt[CAPACITY-1].found;
      res_key_r   <= cell_pkey[CAPACITY-1];
      res_value_r <= cell_pval[CAPACITY-1];
    end
    if (finish) begin
      out_status_r <= status_nxt;
      out_data_r   <= OUT_W'({(count_nxt == '0), count_nxt, oval_nxt, okey_nxt});
    end
  end

  assign ctl.action       = act_r;
  assign ctl.ins_go       = ins_go;
  assign launch_pkt.tok   = launch_r;
  assign launch_pkt.found = 1'b0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]   l_key, r_key, p_key;
    logic [VALUE_BITS-1:0] l_val, r_val, p_val;
    logic                  l_lt;
    sst_pkg::sst_pkt_t     p_in;

    if (i == 0) begin : g_head
      assign l_key = key_r;
      assign l_val = value_r;
      assign l_lt  = 1'b1;
      assign p_in  = launch_pkt;
      assign p_key = '0;
      assign p_val = '0;
    end else begin : g_body
      assign l_key = cell_key[i-1];
      assign l_val = cell_value[i-1];
      assign l_lt  = cell_lt[i-1];
      assign p_in  = cell_pkt[i-1];
      assign p_key = cell_pkey[i-1];
      assign p_val = cell_pval[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign r_key = cell_key[i];
      assign r_val = cell_value[i];
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_val = cell_value[i+1];
    end

    sst_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .cmd_key      (key_r),
      .cmd_value    (value_r),
      .cmd_rank     (CW'(rank_r)),
      .count        (CW'(count_r)),
      .left_key     (l_key),
      .left_value   (l_val),
      .left_lt      (l_lt),
      .right_key    (r_key),
      .right_value  (r_val),
      .pkt_in       (p_in),
      .pkt_key_in   (p_key),
      .pkt_value_in (p_val),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .lt_o         (cell_lt[i]),
      .pkt_o        (cell_pkt[i]),
      .pkt_key_o    (cell_pkey[i]),
      .pkt_value_o  (cell_pval[i])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule
